FILE: sv/lcp_pkg.sv
// Shared types and constants for the lease client protocol block.
// Holds message codes, state codes and the packed records passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcp_pkg;

  // Stream widths
  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 104;
  localparam int M_TUSER_W = 1;

  // Commands carried on the input tuser
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_MSG    = 2'd2;
  localparam logic [1:0] CMD_HANGUP = 2'd3;

  // Client phases
  localparam logic [3:0] PH_INIT  = 4'd0;
  localparam logic [3:0] PH_WOFF  = 4'd1;
  localparam logic [3:0] PH_WACK  = 4'd2;
  localparam logic [3:0] PH_USE   = 4'd3;
  localparam logic [3:0] PH_WEXT  = 4'd4;
  localparam logic [3:0] PH_TERM  = 4'd5;
  localparam logic [3:0] PH_WEXT2 = 4'd6;
  localparam logic [3:0] PH_WOFF2 = 4'd7;
  localparam logic [3:0] PH_WACK2 = 4'd8;

  // Message types
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;
  localparam logic [7:0] MSG_ACK      = 8'd4;
  localparam logic [7:0] MSG_RELEASE  = 8'd5;

  // Message result codes
  localparam logic [7:0] CODE_OK       = 8'd0;
  localparam logic [7:0] CODE_OFFER_NG = 8'd1;
  localparam logic [7:0] CODE_ALLOC    = 8'd2;
  localparam logic [7:0] CODE_EXT      = 8'd3;
  localparam logic [7:0] CODE_ACK_NG   = 8'd4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [7:0] ELAPSED_MAX   = 8'hFF;

  typedef struct packed {
    logic [31:0] netmask;
    logic [31:0] address;
    logic [15:0] ttl;
    logic [7:0]  code;
    logic [7:0]  kind;
  } msg_t;

  typedef struct packed {
    logic [1:0] command;
    msg_t       rx;
  } item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  elapsed;
    logic [15:0] lease_life;
    logic [14:0] lease_period;
    logic [14:0] lease_count;
    logic        handlers_armed;
    logic        done_flag;
    msg_t        msg_buffer;
  } client_t;

  typedef struct packed {
    logic       send_valid;
    msg_t       tx;
    logic [3:0] client_state;
    logic       finished;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/lcp_step.sv
// Next-state and result logic for one request of the lease client.
// Pure combinational; depends on lcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcp_step
  import lcp_pkg::*;
(
  input  wire logic [7:0] timeout_ticks,
  input  wire client_t    cur,
  input  wire item_t      item,
  output client_t         nxt,
  output result_t         res
);

  logic        sent;
  logic        pend;
  logic [7:0]  el_inc;
  logic [14:0] cnt_inc;

  always_comb begin
    nxt     = cur;
    sent    = 1'b0;
    pend    = 1'b0;
    el_inc  = cur.elapsed;
    cnt_inc = cur.lease_count;

    if (!cur.done_flag) begin
      unique case (item.command)
        CMD_START: begin
          if (cur.phase == PH_INIT) begin
            nxt.msg_buffer      = '0;
            nxt.msg_buffer.kind = MSG_DISCOVER;
            sent                = 1'b1;
            nxt.phase           = PH_WOFF;
            nxt.elapsed         = '0;
          end
        end
        CMD_TICK: begin
          if (cur.phase != PH_INIT) begin
            el_inc      = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + 8'd1;
            nxt.elapsed = el_inc;
            if (el_inc >= timeout_ticks) begin
              unique case (cur.phase) inside
                PH_WOFF: begin
                  sent        = 1'b1;
                  nxt.elapsed = '0;
                  nxt.phase   = PH_WOFF2;
                end
                PH_WACK: begin
                  sent        = 1'b1;
                  nxt.elapsed = '0;
                  nxt.phase   = PH_WACK2;
                end
                PH_WEXT: begin
                  sent        = 1'b1;
                  nxt.elapsed = '0;
                  nxt.phase   = PH_WEXT2;
                end
                PH_WOFF2, PH_WACK2, PH_WEXT2: begin
                  nxt.phase     = PH_TERM;
                  nxt.done_flag = 1'b1;
                end
                default: ;
              endcase
            end
            // Lease timer: restart on expiry; expiry before arming ends the client
            if (cur.lease_period != '0) begin
              cnt_inc = cur.lease_count + 15'd1;
              if (cnt_inc >= cur.lease_period) begin
                nxt.lease_count = '0;
                if (!cur.handlers_armed) begin
                  nxt.phase     = PH_TERM;
                  nxt.done_flag = 1'b1;
                end else begin
                  pend = 1'b1;
                end
              end else begin
                nxt.lease_count = cnt_inc;
              end
            end
            if (pend && cur.phase == PH_USE) begin
              nxt.msg_buffer.kind = MSG_REQUEST;
              nxt.msg_buffer.code = CODE_EXT;
              sent                = 1'b1;
              nxt.phase           = PH_WEXT;
              nxt.elapsed         = '0;
            end
          end
        end
        CMD_MSG: begin
          if (cur.phase != PH_INIT) begin
            nxt.msg_buffer = item.rx;
            unique case (cur.phase) inside
              PH_WOFF, PH_WOFF2: begin
                if (item.rx.kind == MSG_OFFER) begin
                  if (item.rx.code == CODE_OK) begin
                    nxt.msg_buffer.kind = MSG_REQUEST;
                    nxt.msg_buffer.code = CODE_ALLOC;
                    nxt.lease_life      = item.rx.ttl;
                    sent                = 1'b1;
                    nxt.phase           = PH_WACK;
                    nxt.elapsed         = '0;
                  end else if (item.rx.code == CODE_OFFER_NG) begin
                    nxt.phase     = PH_TERM;
                    nxt.done_flag = 1'b1;
                  end
                end else begin
                  nxt.phase     = PH_TERM;
                  nxt.done_flag = 1'b1;
                end
              end
              PH_WACK, PH_WACK2, PH_WEXT, PH_WEXT2: begin
                if (item.rx.kind == MSG_ACK) begin
                  nxt.lease_period = cur.lease_life[15:1];
                  nxt.lease_count  = '0;
                  if (item.rx.code == CODE_OK) begin
                    nxt.handlers_armed = 1'b1;
                    nxt.phase          = PH_USE;
                  end else if (item.rx.code == CODE_ACK_NG) begin
                    nxt.phase     = PH_TERM;
                    nxt.done_flag = 1'b1;
                  end
                end else begin
                  nxt.phase     = PH_TERM;
                  nxt.done_flag = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_HANGUP: begin
          if (cur.phase != PH_INIT) begin
            if (!cur.handlers_armed) begin
              nxt.phase     = PH_TERM;
              nxt.done_flag = 1'b1;
            end else if (cur.phase == PH_USE) begin
              nxt.msg_buffer         = '0;
              nxt.msg_buffer.kind    = MSG_RELEASE;
              nxt.msg_buffer.address = cur.msg_buffer.address;
              sent                   = 1'b1;
              nxt.phase              = PH_TERM;
              nxt.done_flag          = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    res.send_valid   = sent;
    res.tx           = sent ? nxt.msg_buffer : '0;
    res.client_state = nxt.phase;
    res.finished     = nxt.done_flag;
  end

endmodule

`default_nettype wire

FILE: sv/lease_client_protocol_fsm.sv
// Top level of the lease client: input register, client state, result register.
// Depends on lcp_pkg and lcp_step.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser: command; tdata: received message
//  m_axis    out  tvalid/tready           tuser: send_valid; tdata: sent message, status
//  cfg       in   cfg_wr_en               cfg_wr_data: timeout_ticks
//
// Each request waits in the input register, where lcp_step works out the next client
// state and the result, and then lands in the result register; a new request is taken
// every cycle while m_axis is not stalled. The client state advances when a request leaves the input
// register, so the following request sees it. A stalled m_axis holds the result
// register and then the input register; s_axis_tready drops only when both are full.
// rst clears both valid flags, the client state and sets timeout_ticks to 10.
`timescale 1ns / 1ps
`default_nettype none

module lease_client_protocol_fsm
  import lcp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // config register
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  // requests in
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // tdata: rx_type[7:0], rx_code[15:8], rx_ttl[31:16], rx_address[63:32],
  //        rx_netmask[95:64]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
  // results out
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: tx_type[7:0], tx_code[15:8], tx_ttl[31:16], tx_address[63:32],
  //        tx_netmask[95:64], client_state[99:96], finished[100], zero[103:101]
  output      logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: send_valid[0]
  output      logic [M_TUSER_W-1:0] m_axis_tuser
);

  logic [7:0] timeout_ticks;
  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_result;
  client_t    client;
  client_t    client_next;
  result_t    step_result;
  logic       advance;

  // Move the held request on when the result register is free or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  // Input register: hold the request until the step logic can hand it on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.command    <= s_axis_tuser[1:0];
      in_item.rx.kind    <= s_axis_tdata[7:0];
      in_item.rx.code    <= s_axis_tdata[15:8];
      in_item.rx.ttl     <= s_axis_tdata[31:16];
      in_item.rx.address <= s_axis_tdata[63:32];
      in_item.rx.netmask <= s_axis_tdata[95:64];
    end
  end

  lcp_step u_step (
    .timeout_ticks (timeout_ticks),
    .cur           (client),
    .item          (in_item),
    .nxt           (client_next),
    .res           (step_result)
  );

  // Client state: advance once per request as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      client <= '0;
    end else if (advance) begin
      client <= client_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid        = out_valid;
  assign m_axis_tuser[0]      = out_result.send_valid;
  assign m_axis_tdata[7:0]    = out_result.tx.kind;
  assign m_axis_tdata[15:8]   = out_result.tx.code;
  assign m_axis_tdata[31:16]  = out_result.tx.ttl;
  assign m_axis_tdata[63:32]  = out_result.tx.address;
  assign m_axis_tdata[95:64]  = out_result.tx.netmask;
  assign m_axis_tdata[99:96]  = out_result.client_state;
  assign m_axis_tdata[100]    = out_result.finished;
  assign m_axis_tdata[103:101] = 3'b000;

endmodule

`default_nettype wire
